// File: rtl/tlbpt_pkg.sv
// Package for the TLB page table translator.
// Holds default sizes, fixed field widths, the controller state type and the
// page table control and status structs. Depends on nothing.
package tlbpt_pkg;

  localparam int TLBPT_TLB_ENTRIES = 16;
  localparam int TLBPT_PAGE_COUNT  = 256;
  localparam int TLBPT_OFFSET_BITS = 8;

  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int HIT_CNT_W   = 32;
  localparam int FAULT_CNT_W = 9;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } pt_ctl_t;

  typedef struct packed {
    logic clearing;
    logic mapped;
  } pt_status_t;

endpackage

// File: rtl/tlbpt_cell.sv
// One TLB cell: holds a valid bit, a page and a frame, compares its page
// with the lookup page and takes its predecessor's entry when told to shift.
// Depends on tlbpt_pkg.
module tlbpt_cell #(
  parameter int PAGE_W = $clog2(tlbpt_pkg::TLBPT_PAGE_COUNT)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              upd,
  input  logic [PAGE_W-1:0] lookup_page,
  input  logic              prev_valid,
  input  logic [PAGE_W-1:0] prev_page,
  input  logic [PAGE_W-1:0] prev_frame,
  input  logic              seen_in,
  input  logic [PAGE_W-1:0] frame_in,
  output logic              valid,
  output logic [PAGE_W-1:0] page,
  output logic [PAGE_W-1:0] frame,
  output logic              seen_out,
  output logic [PAGE_W-1:0] frame_out
);
  import tlbpt_pkg::*;

  logic match;

  assign match     = valid && (page == lookup_page);
  assign seen_out  = seen_in || match;
  assign frame_out = match ? frame : frame_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (upd && !seen_in) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (upd && !seen_in) begin
      page  <= prev_page;
      frame <= prev_frame;
    end
  end

endmodule

// File: rtl/tlbpt_tlb_row.sv
// The TLB as a row of cells kept in recency order, most recent first.
// An update moves the used entry to the front and shifts the ones ahead of it.
// Depends on tlbpt_pkg and tlbpt_cell.
module tlbpt_tlb_row #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLBPT_TLB_ENTRIES,
  parameter int PAGE_COUNT  = tlbpt_pkg::TLBPT_PAGE_COUNT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          upd,
  input  logic [$clog2(PAGE_COUNT)-1:0] lookup_page,
  input  logic [$clog2(PAGE_COUNT)-1:0] miss_frame,
  output logic                          hit,
  output logic [$clog2(PAGE_COUNT)-1:0] use_frame
);
  import tlbpt_pkg::*;

  localparam int PAGE_W = $clog2(PAGE_COUNT);

  logic [TLB_ENTRIES-1:0] cell_valid;
  logic [PAGE_W-1:0]      cell_page  [TLB_ENTRIES];
  logic [PAGE_W-1:0]      cell_frame [TLB_ENTRIES];
  logic [TLB_ENTRIES:0]   seen;
  logic [PAGE_W-1:0]      hit_frame  [TLB_ENTRIES+1];

  assign seen[0]      = 1'b0;
  assign hit_frame[0] = '0;
  assign hit          = seen[TLB_ENTRIES];
  assign use_frame    = hit ? hit_frame[TLB_ENTRIES] : miss_frame;

  for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
    logic              pv;
    logic [PAGE_W-1:0] pp;
    logic [PAGE_W-1:0] pf;

    if (i == 0) begin : g_head
      assign pv = 1'b1;
      assign pp = lookup_page;
      assign pf = use_frame;
    end else begin : g_link
      assign pv = cell_valid[i-1];
      assign pp = cell_page[i-1];
      assign pf = cell_frame[i-1];
    end

    tlbpt_cell #(.PAGE_W(PAGE_W)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .upd        (upd),
      .lookup_page(lookup_page),
      .prev_valid (pv),
      .prev_page  (pp),
      .prev_frame (pf),
      .seen_in    (seen[i]),
      .frame_in   (hit_frame[i]),
      .valid      (cell_valid[i]),
      .page       (cell_page[i]),
      .frame      (cell_frame[i]),
      .seen_out   (seen[i+1]),
      .frame_out  (hit_frame[i+1])
    );
  end

endmodule

// File: rtl/tlbpt_page_table.sv
// Page table memory: one entry per page with a mapped bit and a frame.
// Cleared by a sweep after reset; read and written in clocked blocks.
// Depends on tlbpt_pkg.
module tlbpt_page_table #(
  parameter int PAGE_COUNT = tlbpt_pkg::TLBPT_PAGE_COUNT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tlbpt_pkg::pt_ctl_t            ctl,
  input  logic [$clog2(PAGE_COUNT)-1:0] rd_page,
  input  logic [$clog2(PAGE_COUNT)-1:0] wr_page,
  input  logic [$clog2(PAGE_COUNT)-1:0] wr_frame,
  output tlbpt_pkg::pt_status_t         status,
  output logic [$clog2(PAGE_COUNT)-1:0] rd_frame
);
  import tlbpt_pkg::*;

  localparam int PAGE_W = $clog2(PAGE_COUNT);

  logic [PAGE_W:0]   mem [PAGE_COUNT];
  logic [PAGE_W:0]   rd_q;
  logic              clearing;
  logic [PAGE_W-1:0] clr_idx;

  assign status.clearing = clearing;
  assign status.mapped   = rd_q[PAGE_W];
  assign rd_frame        = rd_q[PAGE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == PAGE_W'(PAGE_COUNT - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (ctl.wr) begin
      mem[wr_page] <= {1'b1, wr_frame};
    end
    if (ctl.rd) begin
      rd_q <= mem[rd_page];
    end
  end

endmodule

// File: rtl/tlb_page_table_translator.sv
// On a translation the accept edge reads the page table, and in the busy state
// the design compares the page against every TLB cell, refills the row in
// recency order, writes the page table on a fault and loads the result
// register. A result that waits on a stalled output holds the busy state.
// After reset the page table is swept clear, during which no beat is accepted.
module tlb_page_table_translator #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLBPT_TLB_ENTRIES,
  parameter int PAGE_COUNT  = tlbpt_pkg::TLBPT_PAGE_COUNT,
  parameter int OFFSET_BITS = tlbpt_pkg::TLBPT_OFFSET_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [tlbpt_pkg::ADDR_W-1:0]         logical_address,
  input  logic signed [tlbpt_pkg::DATA_W-1:0]  store_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [tlbpt_pkg::ADDR_W-1:0]         physical_address,
  output logic signed [tlbpt_pkg::DATA_W-1:0]  data_byte,
  output logic                                 tlb_hit,
  output logic                                 frame_fault,
  output logic [tlbpt_pkg::HIT_CNT_W-1:0]      hit_count,
  output logic [tlbpt_pkg::FAULT_CNT_W-1:0]    fault_count
);
  import tlbpt_pkg::*;

  localparam int PAGE_W  = $clog2(PAGE_COUNT);
  localparam int NEXT_W  = $clog2(PAGE_COUNT + 1);
  localparam int VPN_W   = (OFFSET_BITS < ADDR_W) ? ADDR_W - OFFSET_BITS : 1;
  localparam int STEPS   = (VPN_W > PAGE_W) ? VPN_W - PAGE_W + 1 : 1;

  state_t                   state;
  logic                     accept;
  logic                     proceed;
  logic [31:0]              vpn_wide;
  logic [VPN_W-1:0]         vpn_rem;
  logic [PAGE_W-1:0]        page_in;
  logic [PAGE_W-1:0]        page_reg;
  logic [OFFSET_BITS-1:0]   offset_reg;
  logic signed [DATA_W-1:0] byte_reg;
  logic [NEXT_W-1:0]        next_frame;
  logic [HIT_CNT_W-1:0]     hits_total;
  logic [FAULT_CNT_W-1:0]   faults_total;
  logic [HIT_CNT_W-1:0]     hits_next;
  logic [FAULT_CNT_W-1:0]   faults_next;
  logic                     hit;
  logic                     fault;
  logic [PAGE_W-1:0]        use_frame;
  logic [PAGE_W-1:0]        miss_frame;
  logic [PAGE_W-1:0]        pt_frame;
  logic [31:0]              pa_wide;
  pt_ctl_t                  pt_ctl;
  pt_status_t               pt_status;

  assign in_stall = (state != ST_IDLE) || pt_status.clearing;
  assign accept   = in_valid && !in_stall;
  assign proceed  = (state == ST_BUSY) && (!out_valid || !out_stall);

  // The page number is reduced modulo the page count by constant subtractions.
  always_comb begin
    vpn_wide = 32'(logical_address) >> OFFSET_BITS;
    vpn_rem  = vpn_wide[VPN_W-1:0];
    for (int k = STEPS - 1; k >= 0; k--) begin
      if (32'(vpn_rem) >= (32'(PAGE_COUNT) << k)) begin
        vpn_rem = vpn_rem - VPN_W'(32'(PAGE_COUNT) << k);
      end
    end
    page_in = PAGE_W'(vpn_rem);
  end

  assign miss_frame = pt_status.mapped ? pt_frame : next_frame[PAGE_W-1:0];
  assign fault      = !hit && !pt_status.mapped;
  assign pt_ctl.rd  = accept;
  assign pt_ctl.wr  = proceed && fault;

  assign hits_next   = (hit && (hits_total != '1)) ? hits_total + 1'b1 : hits_total;
  assign faults_next = (fault && (faults_total != '1)) ? faults_total + 1'b1 : faults_total;
  assign pa_wide     = (32'(use_frame) << OFFSET_BITS) | 32'(offset_reg);

  tlbpt_page_table #(.PAGE_COUNT(PAGE_COUNT)) u_page_table (
    .clk     (clk),
    .rst     (rst),
    .ctl     (pt_ctl),
    .rd_page (page_in),
    .wr_page (page_reg),
    .wr_frame(next_frame[PAGE_W-1:0]),
    .status  (pt_status),
    .rd_frame(pt_frame)
  );

  tlbpt_tlb_row #(
    .TLB_ENTRIES(TLB_ENTRIES),
    .PAGE_COUNT (PAGE_COUNT)
  ) u_tlb_row (
    .clk        (clk),
    .rst        (rst),
    .upd        (proceed),
    .lookup_page(page_reg),
    .miss_frame (miss_frame),
    .hit        (hit),
    .use_frame  (use_frame)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      next_frame   <= '0;
      hits_total   <= '0;
      faults_total <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (proceed) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (proceed) begin
        out_valid    <= 1'b1;
        hits_total   <= hits_next;
        faults_total <= faults_next;
        if (fault) begin
          next_frame <= next_frame + 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page_reg   <= page_in;
      offset_reg <= logical_address[OFFSET_BITS-1:0];
      byte_reg   <= store_byte;
    end
    if (proceed) begin
      physical_address <= pa_wide[ADDR_W-1:0];
      data_byte        <= byte_reg;
      tlb_hit          <= hit;
      frame_fault      <= fault;
      hit_count        <= hits_next;
      fault_count      <= faults_next;
    end
  end

endmodule

// File: rtl/tlbpt_checker.sv
// Port-level checks for the TLB page table translator, bound to the top level.
// Depends on tlbpt_pkg and tlb_page_table_translator.
module tlbpt_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              tlb_hit,
  input logic                              frame_fault,
  input logic [tlbpt_pkg::HIT_CNT_W-1:0]   hit_count,
  input logic [tlbpt_pkg::FAULT_CNT_W-1:0] fault_count
);
  import tlbpt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("A stalled result beat was dropped.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("A new beat was accepted while a translation was in progress.");

  a_hit_or_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tlb_hit && frame_fault) &&
                  (!tlb_hit || hit_count != '0) &&
                  (!frame_fault || fault_count != '0))
    else $error("Result flags disagree with each other or with the counts.");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("A result beat was shown right after reset.");

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .tlb_hit    (tlb_hit),
  .frame_fault(frame_fault),
  .hit_count  (hit_count),
  .fault_count(fault_count)
);
